FILE: hw/rtl/register_vm_instruction_executor_assert.svh
// Assertion macros for the register VM executor.
`ifndef REGISTER_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define REGISTER_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH

`define RVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define RVM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hw/rtl/rvm_pkg.sv
package rvm_pkg;

  localparam int unsigned NumRegs   = 32;
  localparam int unsigned RegAw     = $clog2(NumRegs);
  localparam int unsigned ProgDepth = 256;
  localparam int unsigned PcW       = 9;
  localparam int unsigned NumArgs   = 4;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [CfgIdxW-1:0] CfgProgLen = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgArg0    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgArg3    = 3'd4;

  typedef enum logic [3:0] {
    OpLoadi = 4'd0, OpLoada = 4'd1, OpMov = 4'd2, OpRet = 4'd3,
    OpAdd = 4'd4, OpSub = 4'd5, OpMul = 4'd6, OpDiv = 4'd7,
    OpMod = 4'd8, OpJz = 4'd9, OpForprep = 4'd10, OpForloop = 4'd11,
    OpJmp = 4'd12, OpNop = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    StRun = 2'd0, StRet = 2'd1, StPastEnd = 2'd2, StDivZero = 2'd3
  } status_e;

  localparam logic [1:0] KindImm = 2'd0;
  localparam logic [1:0] KindReg = 2'd1;
  localparam logic [1:0] KindArg = 2'd2;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [4:0]  dest_reg;
    logic [1:0]  a_kind;
    logic [31:0] a_value;
    logic        b_kind;
    logic [31:0] b_value;
    logic [7:0]  jump_target;
  } req_t;

  typedef struct packed {
    logic [PcW-1:0] next_pc;
    logic           done_res;
    logic [31:0]    return_value;
    logic [1:0]     status;
  } rsp_t;

  typedef struct packed {
    logic        start;
    logic        signed_op;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

FILE: hw/rtl/rvm_ram.sv
module rvm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: hw/rtl/rvm_div.sv
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
module rvm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rvm_pkg::div_req_t req_i,
  output rvm_pkg::div_rsp_t rsp_o
);
  import rvm_pkg::*;

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic        negq_q, negq_d, negr_q, negr_d;
  logic        done_q, done_d;
  logic [31:0] mag_a, mag_b;
  logic [32:0] trial, shifted;

  always_comb begin
    mag_a = (req_i.signed_op && req_i.dividend[31]) ? 32'(-req_i.dividend) : req_i.dividend;
    mag_b = (req_i.signed_op && req_i.divisor[31]) ? 32'(-req_i.divisor) : req_i.divisor;
    shifted = {rem_q[31:0], quo_q[31]};
    trial = shifted - {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    negq_d = negq_q;
    negr_d = negr_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = '0;
      quo_d = mag_a;
      rem_d = '0;
      dvs_d = mag_b;
      negq_d = req_i.signed_op && (req_i.dividend[31] ^ req_i.divisor[31]);
      negr_d = req_i.signed_op && req_i.dividend[31];
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = negq_q ? 32'(-quo_q) : quo_q;
  assign rsp_o.rem  = negr_q ? 32'(-rem_q[31:0]) : rem_q[31:0];

endmodule

FILE: hw/rtl/register_vm_instruction_executor.sv
// Most items: register read (SRead), then execute and write back; multiply also passes
// through SMul, and div/mod with a usable divisor wait in SDiv for the serial divider.
// Throughput: one item at a time; busy is high from acceptance until the result strobe.
// Reset: pc, halt flag and program length/arguments clear; register file is not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
module register_vm_instruction_executor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  rvm_pkg::req_t                  req_i,
  output logic                           valid_o,
  output rvm_pkg::rsp_t                  rsp_o,
  input  logic                           cfg_we_i,
  input  logic [rvm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [31:0]                    cfg_data_i
);
  import rvm_pkg::*;
  `include "register_vm_instruction_executor_assert.svh"

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SMul  = 3'd2;
  localparam logic [2:0] SDiv  = 3'd3;

  logic [2:0]     st_q, st_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic           halt_q, halt_d;
  logic [PcW-1:0] plen_q;
  logic [31:0]    args_q [NumArgs];
  req_t           req_q;
  logic           valid_q, valid_d;
  rsp_t           rsp_q, rsp_d;
  logic [31:0]    prod_q;

  logic             we;
  logic [RegAw-1:0] waddr, ra_a, ra_b;
  logic [31:0]      wdata, rd_a, rd_b, rd_d;
  logic [RegAw-1:0] ra_d;
  logic [31:0]      unused_rd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [PcW-1:0] len;
  logic [31:0]    opa, opb, argv;
  logic [PcW-1:0] npc;
  logic           stop;
  logic [1:0]     stat;
  logic [31:0]    retv;
  logic           ovf;

  assign len = (plen_q > PcW'(ProgDepth)) ? PcW'(ProgDepth) : plen_q;
  assign busy = (st_q != SIdle);
  assign valid_o = valid_q;
  assign rsp_o = rsp_q;

  // Port a: operand A / compare reg; port b: operand B; second RAM copy for dest.
  assign ra_a = (start && !busy) ? req_i.a_value[RegAw-1:0] : req_q.a_value[RegAw-1:0];
  assign ra_b = (start && !busy) ? req_i.b_value[RegAw-1:0] : req_q.b_value[RegAw-1:0];
  assign ra_d = (start && !busy) ? req_i.dest_reg[RegAw-1:0] : req_q.dest_reg[RegAw-1:0];

  rvm_ram #(.Width(32), .Depth(NumRegs)) u_rf_ab (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(ra_a), .rdata_a_o(rd_a), .raddr_b_i(ra_b), .rdata_b_o(rd_b)
  );

  rvm_ram #(.Width(32), .Depth(NumRegs)) u_rf_d (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(ra_d), .rdata_a_o(rd_d), .raddr_b_i(ra_d), .rdata_b_o(unused_rd)
  );

  rvm_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  assign argv = args_q[req_q.a_value[1:0]];
  assign opa = (req_q.a_kind == KindReg) ? rd_a : (req_q.a_kind == KindArg) ? argv
             : req_q.a_value;
  assign opb = req_q.b_kind ? rd_b : req_q.b_value;
  assign ovf = (opa == 32'h8000_0000) && (opb == 32'hFFFF_FFFF);

  always_comb begin
    st_d = st_q;
    pc_d = pc_q;
    halt_d = halt_q;
    valid_d = 1'b0;
    rsp_d = rsp_q;
    we = 1'b0;
    waddr = req_q.dest_reg[RegAw-1:0];
    wdata = opa;
    npc = PcW'(pc_q + PcW'(1));
    stop = 1'b0;
    stat = StRun;
    retv = '0;
    div_req = '{start: 1'b0, signed_op: 1'b1, dividend: opa, divisor: opb};
    case (st_q)
      SIdle: begin
        if (start) begin
          if (halt_q) begin
            valid_d = 1'b1;
            rsp_d = '{next_pc: pc_q, done_res: 1'b1, return_value: '0, status: StRun};
          end else if (pc_q >= len) begin
            valid_d = 1'b1;
            halt_d = 1'b1;
            rsp_d = '{next_pc: pc_q, done_res: 1'b1, return_value: '0, status: StPastEnd};
          end else begin
            st_d = SRead;
          end
        end
      end
      SRead, SMul, SDiv: begin
        if (st_q == SRead && req_q.req_type == OpMul) begin
          st_d = SMul;
        end else if (st_q == SRead && (req_q.req_type == OpDiv || req_q.req_type == OpMod)
                     && opb != '0 && !ovf) begin
          st_d = SDiv;
          div_req.start = 1'b1;
        end else if (st_q == SDiv && !div_rsp.done) begin
          st_d = SDiv;
        end else begin
          st_d = SIdle;
          valid_d = 1'b1;
          case (req_q.req_type)
            OpLoadi: begin we = 1'b1; wdata = req_q.a_value; end
            OpLoada: begin
              we = 1'b1;
              wdata = (req_q.a_kind == KindArg) ? argv : req_q.a_value;
            end
            OpMov: we = 1'b1;
            OpRet: begin retv = rd_d; stat = StRet; stop = 1'b1; end
            OpAdd: begin we = 1'b1; wdata = opa + opb; end
            OpSub: begin we = 1'b1; wdata = opa - opb; end
            OpMul: begin we = 1'b1; wdata = prod_q; end
            OpDiv, OpMod: begin
              if (opb == '0) begin
                stat = StDivZero;
                stop = 1'b1;
                npc = pc_q;
              end else begin
                we = 1'b1;
                if (ovf) begin
                  wdata = (req_q.req_type == OpDiv) ? 32'h8000_0000 : '0;
                end else begin
                  wdata = (req_q.req_type == OpDiv) ? div_rsp.quot : div_rsp.rem;
                end
              end
            end
            OpJz: if (rd_d == '0) npc = PcW'({1'b0, req_q.jump_target} + PcW'(1));
            OpForprep: begin
              if (!($signed(rd_d) >= $signed(rd_a))) begin
                npc = PcW'(pc_q + PcW'(req_q.jump_target));
              end
            end
            OpForloop: begin
              if ($signed(rd_d) >= $signed(rd_a)) begin
                we = 1'b1;
                wdata = rd_d - 32'd1;
                npc = PcW'(pc_q - PcW'(req_q.jump_target));
              end
            end
            OpJmp: npc = PcW'({1'b0, req_q.jump_target} + PcW'(1));
            default: ;
          endcase
          if (!stop && npc >= len) begin
            stat = StPastEnd;
            stop = 1'b1;
          end
          pc_d = npc;
          if (stop) halt_d = 1'b1;
          rsp_d = '{next_pc: npc, done_res: stop, return_value: retv, status: stat};
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= SIdle;
      pc_q    <= '0;
      halt_q  <= 1'b0;
      valid_q <= 1'b0;
      plen_q  <= '0;
      for (int i = 0; i < NumArgs; i++) args_q[i] <= '0;
    end else begin
      st_q    <= st_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgProgLen) begin
          plen_q <= cfg_data_i[PcW-1:0];
        end else if (cfg_idx_i >= CfgArg0 && cfg_idx_i <= CfgArg3) begin
          args_q[2'(cfg_idx_i - CfgArg0)] <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    prod_q <= 32'(opa * opb);
    if (start && !busy) req_q <= req_i;
  end

  `RVM_ASSERT(a_halt_stays, halt_q |=> halt_q, "halt flag dropped without reset")
  `RVM_ASSERT(a_done_sets_halt, (valid_q && rsp_q.done_res) |-> halt_q,
              "stop reported without halting")
  `RVM_ASSERT(a_idle_result, valid_q |-> (st_q == SIdle), "result while still executing")
  `RVM_ASSERT_RST(a_div_only_busy, !rst_ni || !div_rsp.done || (st_q == SDiv),
                  "divider finished outside divide state")

endmodule
